FILE: sv/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Shared request codes, status codes, controller states and the command and
// status bundles between the symbol table controller and its datapath.
// ----------------------------------------------------------------------------
package sst_pkg;

   // request codes
   localparam logic [2:0] REQ_PUSH      = 3'd0;
   localparam logic [2:0] REQ_POP       = 3'd1;
   localparam logic [2:0] REQ_DEF_VAR   = 3'd2;
   localparam logic [2:0] REQ_DEF_CONST = 3'd3;
   localparam logic [2:0] REQ_LOOKUP    = 3'd4;
   localparam logic [2:0] REQ_ASSIGN    = 3'd5;

   // response status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND   = 3'd1;
   localparam logic [2:0] ST_CONSTANT    = 3'd2;
   localparam logic [2:0] ST_DEFINED     = 3'd3;
   localparam logic [2:0] ST_TABLE_FULL  = 3'd4;
   localparam logic [2:0] ST_SCOPES_FULL = 3'd5;

   typedef enum logic [1:0] {
      S_IDLE,
      S_START,
      S_SCAN
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       scan_init;
      logic       scan_step;
      logic       push;
      logic       pop;
      logic       define_wr;
      logic       assign_wr;
      logic       emit;
      logic       emit_value;
      logic [2:0] status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] op;
      logic       hit;
      logic       hit_const;
      logic       exhausted;
      logic       entries_full;
      logic       scopes_full;
      logic       rsp_free;
   } stat_type;

endpackage

FILE: sv/sst_ctrl.sv
// ----------------------------------------------------------------------------
// sst_ctrl
// Sequencer for the symbol table: takes a request, runs the scope update or
// the newest-first entry search, and issues the final table update and the
// response.
// ----------------------------------------------------------------------------
module sst_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sst_pkg::stat_type stat,
   output sst_pkg::cmd_type  cmd
);

   sst_pkg::state_type state_ff;
   sst_pkg::state_type state_in;
   logic               is_define;
   logic               scan_op;
   logic               scan_done;

   assign is_define = (stat.op == sst_pkg::REQ_DEF_VAR) ||
                      (stat.op == sst_pkg::REQ_DEF_CONST);
   assign scan_op   = is_define || (stat.op == sst_pkg::REQ_LOOKUP) ||
                      (stat.op == sst_pkg::REQ_ASSIGN);
   assign scan_done = stat.hit || stat.exhausted;
   assign req_stall = (state_ff != sst_pkg::S_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sst_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = sst_pkg::S_START;
            end
         end
         sst_pkg::S_START: begin
            if (scan_op) begin
               state_in = sst_pkg::S_SCAN;
            end else if (stat.rsp_free) begin
               state_in = sst_pkg::S_IDLE;
            end
         end
         sst_pkg::S_SCAN: begin
            if (scan_done && stat.rsp_free) begin
               state_in = sst_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sst_pkg::S_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd        = '0;
      cmd.status = sst_pkg::ST_OK;
      case (state_ff)
         sst_pkg::S_IDLE: begin
            cmd.load = req_valid;
         end
         sst_pkg::S_START: begin
            if (scan_op) begin
               cmd.scan_init = 1'b1;
            end else if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               case (stat.op)
                  sst_pkg::REQ_PUSH: begin
                     if (stat.scopes_full) begin
                        cmd.status = sst_pkg::ST_SCOPES_FULL;
                     end else begin
                        cmd.push = 1'b1;
                     end
                  end
                  sst_pkg::REQ_POP: begin
                     cmd.pop = 1'b1;
                  end
                  default: begin
                     cmd.status = sst_pkg::ST_OK;
                  end
               endcase
            end
         end
         sst_pkg::S_SCAN: begin
            if (!scan_done) begin
               cmd.scan_step = 1'b1;
            end else if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               if (stat.hit) begin
                  // key found at the slot under compare
                  if (is_define) begin
                     cmd.status = sst_pkg::ST_DEFINED;
                  end else if (stat.op == sst_pkg::REQ_LOOKUP) begin
                     cmd.emit_value = 1'b1;
                  end else if (stat.hit_const) begin
                     cmd.status = sst_pkg::ST_CONSTANT;
                  end else begin
                     cmd.assign_wr = 1'b1;
                  end
               end else begin
                  // search ran out without a match
                  if (!is_define) begin
                     cmd.status = sst_pkg::ST_NOT_FOUND;
                  end else if (stat.entries_full) begin
                     cmd.status = sst_pkg::ST_TABLE_FULL;
                  end else begin
                     cmd.define_wr = 1'b1;
                  end
               end
            end
         end
         default: begin
            cmd.status = sst_pkg::ST_OK;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sst_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/sst_dp.sv
// ----------------------------------------------------------------------------
// sst_dp
// Symbol table datapath: entry and scope mark memories, entry and scope
// counters, the one-entry-per-cycle search pipeline and the response register.
// ----------------------------------------------------------------------------
module sst_dp #(
   parameter int ENTRIES    = 256,
   parameter int SCOPES     = 64,
   parameter int KEY_BITS   = 16,
   parameter int VALUE_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sst_pkg::cmd_type      cmd,
   output sst_pkg::stat_type     stat,
   input  logic [2:0]            req_type,
   input  logic [KEY_BITS-1:0]   req_key,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_status,
   output logic [VALUE_BITS-1:0] rsp_read_value
);

   localparam int AW  = $clog2(ENTRIES);
   localparam int CW  = $clog2(ENTRIES + 1);
   localparam int SAW = (SCOPES > 1) ? $clog2(SCOPES) : 1;
   localparam int SCW = $clog2(SCOPES + 1);
   localparam logic [CW-1:0]  ENTRY_MAX = CW'(ENTRIES);
   localparam logic [SCW-1:0] SCOPE_MAX = SCW'(SCOPES);

   // storage
   logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
   logic                  const_mem [ENTRIES];
   logic [VALUE_BITS-1:0] value_mem [ENTRIES];
   logic [CW-1:0]         mark_mem  [SCOPES];

   // captured request
   logic [2:0]            op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;

   // table and scope counters
   logic [CW-1:0]  entry_count_ff, entry_count_in;
   logic [SCW-1:0] scope_count_ff, scope_count_in;
   logic [CW-1:0]  mark_rd_ff;

   // search pipeline
   logic [CW-1:0]         ptr_ff, ptr_in;
   logic [CW-1:0]         floor_ff, floor_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [AW-1:0]         rd_idx_ff, rd_idx_in;
   logic [KEY_BITS-1:0]   key_rd_ff;
   logic                  const_rd_ff;
   logic [VALUE_BITS-1:0] value_rd_ff;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            rsp_status_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff;

   logic                  is_define;
   logic                  scope_nonzero;
   logic [SCW-1:0]        scope_dec;
   logic [SAW-1:0]        mark_rd_addr;
   logic [CW-1:0]         cur_floor;
   logic [CW-1:0]         ptr_dec;
   logic [AW-1:0]         scan_addr;
   logic                  scan_more;
   logic                  scan_rd;
   logic [AW-1:0]         entry_idx;
   logic                  value_wr_en;
   logic [AW-1:0]         value_wr_addr;

   assign is_define     = (op_ff == sst_pkg::REQ_DEF_VAR) ||
                          (op_ff == sst_pkg::REQ_DEF_CONST);
   assign scope_nonzero = (scope_count_ff != '0);
   assign scope_dec     = scope_count_ff - SCW'(1);
   assign mark_rd_addr  = scope_dec[SAW-1:0];
   assign cur_floor     = scope_nonzero ? mark_rd_ff : '0;
   assign ptr_dec       = ptr_ff - CW'(1);
   assign scan_addr     = ptr_dec[AW-1:0];
   assign scan_more     = (ptr_ff > floor_ff);
   assign scan_rd       = cmd.scan_step && scan_more;
   assign entry_idx     = entry_count_ff[AW-1:0];
   assign value_wr_en   = cmd.define_wr || cmd.assign_wr;
   assign value_wr_addr = cmd.define_wr ? entry_idx : rd_idx_ff;

   // status back to the controller
   always_comb begin
      stat              = '0;
      stat.op           = op_ff;
      stat.hit          = rd_valid_ff && (key_rd_ff == key_ff);
      stat.hit_const    = const_rd_ff;
      stat.exhausted    = !rd_valid_ff && !scan_more;
      stat.entries_full = (entry_count_ff >= ENTRY_MAX);
      stat.scopes_full  = (scope_count_ff >= SCOPE_MAX);
      stat.rsp_free     = !rsp_valid_ff || !rsp_stall;
   end

   // counter updates
   always_comb begin
      entry_count_in = entry_count_ff;
      scope_count_in = scope_count_ff;
      if (cmd.push) begin
         scope_count_in = scope_count_ff + SCW'(1);
      end
      if (cmd.pop) begin
         entry_count_in = cur_floor;
         scope_count_in = scope_nonzero ? scope_dec : '0;
      end
      if (cmd.define_wr) begin
         entry_count_in = entry_count_ff + CW'(1);
      end
   end

   // search pointer walks from the newest entry down to the floor
   always_comb begin
      ptr_in      = ptr_ff;
      floor_in    = floor_ff;
      rd_valid_in = rd_valid_ff;
      rd_idx_in   = rd_idx_ff;
      if (cmd.scan_init) begin
         ptr_in      = entry_count_ff;
         floor_in    = is_define ? cur_floor : '0;
         rd_valid_in = 1'b0;
      end else if (cmd.scan_step) begin
         if (scan_more) begin
            ptr_in      = ptr_dec;
            rd_valid_in = 1'b1;
            rd_idx_in   = scan_addr;
         end else begin
            rd_valid_in = 1'b0;
         end
      end
   end

   // response valid holds until the transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         scope_count_ff <= '0;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         entry_count_ff <= entry_count_in;
         scope_count_ff <= scope_count_in;
         rd_valid_ff    <= rd_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      floor_ff  <= floor_in;
      rd_idx_ff <= rd_idx_in;
      if (cmd.load) begin
         op_ff    <= req_type;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      if (cmd.emit) begin
         rsp_status_ff <= cmd.status;
         rsp_value_ff  <= cmd.emit_value ? value_rd_ff : '0;
      end
   end

   // entry memories
   always_ff @(posedge clock) begin
      if (scan_rd) begin
         key_rd_ff   <= key_mem[scan_addr];
         const_rd_ff <= const_mem[scan_addr];
         value_rd_ff <= value_mem[scan_addr];
      end
      if (cmd.define_wr) begin
         key_mem[entry_idx]   <= key_ff;
         const_mem[entry_idx] <= (op_ff == sst_pkg::REQ_DEF_CONST);
      end
      if (value_wr_en) begin
         value_mem[value_wr_addr] <= value_ff;
      end
   end

   // scope mark memory, newest mark read every cycle
   always_ff @(posedge clock) begin
      mark_rd_ff <= mark_mem[mark_rd_addr];
      if (cmd.push) begin
         mark_mem[scope_count_ff[SAW-1:0]] <= entry_count_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

FILE: sv/scoped_symbol_table.sv
// ----------------------------------------------------------------------------
// scoped_symbol_table
// Scoped symbol table: a stack of key/value entries marked variable or
// constant, with a stack of scope marks for nested scopes.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_type, req_key, req_value) transfers when req_valid is high
//   and req_stall is low; every request gives exactly one response
//   (rsp_status, rsp_read_value) that transfers when rsp_valid is high and
//   rsp_stall is low. One request is worked on at a time.
//   Push scope, pop scope and unused codes are answered from the start
//   state without a search. Define, lookup and assign search the entry
//   memory from the newest entry down, one entry per cycle through the
//   registered read port (down to the newest scope mark for define, down to
//   entry zero for lookup and assign). The search stops at the first entry
//   whose key matches, or once every entry down to that floor has been
//   searched without a match.
//   A new request is taken the cycle after the response is registered, even
//   while that response waits on rsp_stall; the next response then waits in
//   the controller until the output register frees up.
//   Synchronous reset empties the table and the scope stack at once; the
//   memories are not cleared, since only entries below the counts are read.
// ----------------------------------------------------------------------------
module scoped_symbol_table #(
   parameter int ENTRIES    = 256,
   parameter int SCOPES     = 64,
   parameter int KEY_BITS   = 16,
   parameter int VALUE_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_type,
   input  logic [KEY_BITS-1:0]   req_key,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_status,
   output logic [VALUE_BITS-1:0] rsp_read_value
);

   sst_pkg::cmd_type  cmd;
   sst_pkg::stat_type stat;

   // sequencer
   sst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage, search and response
   sst_dp #(
      .ENTRIES    (ENTRIES),
      .SCOPES     (SCOPES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_type       (req_type),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value)
   );

   // block goes busy right after taking a request
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted but block did not go busy");

   // only a successful lookup carries a value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != sst_pkg::ST_OK)) |-> (rsp_read_value == '0))
      else $error("failed request returned a nonzero value");

   // status codes stay in the defined range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= sst_pkg::ST_SCOPES_FULL))
      else $error("response status out of range");

endmodule
